FILE: rtl/bgra_to_yuv420_converter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the BGRA to YUV 4:2:0 converter
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BGRA_TO_YUV420_CONVERTER_ASSERT_SVH
`define BGRA_TO_YUV420_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGR2YUV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGR2YUV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bgr2yuv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter package
// Widths, register codes, conversion constants and small helper functions.
// ----------------------------------------------------------------------------
package bgr2yuv_pkg;

  // Configuration port widths.
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  // Width that holds any effective frame size, up to 8192.
  localparam int unsigned SIZE_W    = 14;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  // Pair sums are 9 bits per colour; a line entry holds red, green, blue.
  localparam int unsigned PAIR_W = 9;
  localparam int unsigned LINE_W = 3 * PAIR_W;

  // Luma coefficients and offsets (BT.601 studio range).
  localparam logic [15:0] LUMA_R   = 16'd66;
  localparam logic [15:0] LUMA_G   = 16'd129;
  localparam logic [15:0] LUMA_B   = 16'd25;
  localparam logic [15:0] ROUND_U  = 16'd128;
  localparam logic [8:0]  LUMA_OFS = 9'd16;

  // Chroma coefficients, signed.
  localparam logic signed [17:0] CB_R    = -18'sd38;
  localparam logic signed [17:0] CB_G    = -18'sd74;
  localparam logic signed [17:0] CB_B    = 18'sd112;
  localparam logic signed [17:0] CR_R    = 18'sd112;
  localparam logic signed [17:0] CR_G    = -18'sd94;
  localparam logic signed [17:0] CR_B    = -18'sd18;
  localparam logic signed [17:0] ROUND_S = 18'sd128;
  // Adding this bias before the shift gives floor(x / 256) + 128.
  localparam logic signed [17:0] C_BIAS  = 18'sd32768;

  // Clamp a register value to 2..maxv and force it even.
  function automatic logic [SIZE_W-1:0] eff_size(logic [CFG_W-1:0] v,
                                                 logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] t;
    t = {1'b0, v};
    if (t < SIZE_W'(2)) begin
      t = SIZE_W'(2);
    end
    if (t > maxv) begin
      t = maxv;
    end
    t[0] = 1'b0;
    return t;
  endfunction

  // Biased, shifted chroma sum clamped to a byte.
  function automatic logic [7:0] chroma_byte(logic signed [17:0] x);
    logic signed [17:0] t;
    logic [9:0]         q;
    t = x + C_BIAS;
    q = t[17:8];
    if (t[17]) begin
      return 8'd0;
    end else if (q > 10'd255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

endpackage

FILE: rtl/bgr2yuv_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter channel interfaces
// Valid/ready channels for pixels in, results out and configuration writes.
// ----------------------------------------------------------------------------

// One pixel item.
interface bgr2yuv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// One result item.
interface bgr2yuv_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] cb;
  logic [7:0] cr;
  logic       frame_end;

  modport source (output valid, output luma, output chroma_valid, output cb, output cr,
                  output frame_end, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input cb, input cr,
                  input frame_end, output ready);
endinterface

// Configuration register write.
interface bgr2yuv_cfg_if import bgr2yuv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bgr2yuv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module bgr2yuv_ram #(
  parameter int unsigned WIDTH  = 27,
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bgra_to_yuv420_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter
// Raster-order pixels in, BT.601 luma per pixel and 2x2 block chroma out.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock while pix_i.ready is high and
// gives one result item per pixel, through a line-store access, the luma
// products and block averages, then the chroma products into the output
// register. Each stage holds only while the one after it is full and stalled,
// so a waiting result does not stop new pixels while the pipeline has room.
// Pair sums of each even row sit in a line store of MAX_WIDTH/2 entries of
// 27 bits, written on even rows and read on odd rows with one access per
// pixel pair; it needs no clearing after reset. Frame sizes are clamped to
// 2..MAX_WIDTH and 2..MAX_HEIGHT and made even; a new size acts at once.

module bgra_to_yuv420_converter
  import bgr2yuv_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bgr2yuv_pix_if.sink   pix_i,
  bgr2yuv_res_if.source res_o,
  bgr2yuv_cfg_if.sink   cfg_i
);

  `include "bgra_to_yuv420_converter_assert.svh"

  localparam int unsigned CNT_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Stage after the line-store access.
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [PAIR_W-1:0] sum_r;
    logic [PAIR_W-1:0] sum_g;
    logic [PAIR_W-1:0] sum_b;
    logic              chroma;
    logic              fend;
  } s1_t;

  // Stage after luma and block averages.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] avg_r;
    logic [7:0] avg_g;
    logic [7:0] avg_b;
    logic       chroma;
    logic       fend;
  } s2_t;

  // Output register.
  typedef struct packed {
    logic [7:0] luma;
    logic       chroma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       fend;
  } s3_t;

  logic [CFG_W-1:0]  width_q, width_d, height_q, height_d;
  logic [SIZE_W-1:0] width_eff, height_eff;
  logic [CNT_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [23:0]       left_q, left_d;
  logic              v1_q, v2_q, v3_q;
  s1_t               s1_q, s1_d;
  s2_t               s2_q, s2_d;
  s3_t               s3_q, s3_d;
  logic              en1, en2, en3;
  logic              pix_acc;
  logic              row_last, frame_last;
  logic [PAIR_W-1:0] pair_r, pair_g, pair_b;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [LINE_W-1:0] mem_wdata, mem_rdata;
  logic [15:0]       y_sum;
  logic [8:0]        y_ofs;
  logic [9:0]        blk_r, blk_g, blk_b;
  logic signed [17:0] ar_s, ag_s, ab_s, cb_x, cr_x;

  // Configuration registers, always ready.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FRAME_WIDTH:  width_d  = cfg_i.data;
        REG_FRAME_HEIGHT: height_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  assign width_eff  = eff_size(width_q, SIZE_W'(MAX_WIDTH));
  assign height_eff = eff_size(height_q, SIZE_W'(MAX_HEIGHT));

  // Stage enables: a stage moves when the one after it is empty or moving.
  assign en3         = !v3_q || res_o.ready;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign pix_i.ready = en1;
  assign pix_acc     = pix_i.valid && en1;

  // Position in the frame and horizontal pair sums.
  assign row_last   = (SIZE_W'(col_q) + SIZE_W'(1)) >= width_eff;
  assign frame_last = row_last && ((SIZE_W'(row_q) + SIZE_W'(1)) >= height_eff);
  assign pair_b     = PAIR_W'(pix_i.blue)  + PAIR_W'(left_q[7:0]);
  assign pair_g     = PAIR_W'(pix_i.green) + PAIR_W'(left_q[15:8]);
  assign pair_r     = PAIR_W'(pix_i.red)   + PAIR_W'(left_q[23:16]);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (pix_acc) begin
      if (!col_q[0]) begin
        left_d = {pix_i.red, pix_i.green, pix_i.blue};
      end
      if (row_last) begin
        col_d = '0;
        if (frame_last) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  // Line store: even rows write the pair sums, odd rows read them back.
  assign mem_addr  = ADDR_W'(col_q >> 1);
  assign mem_we    = pix_acc && col_q[0] && !row_q[0];
  assign mem_re    = pix_acc && col_q[0] && row_q[0];
  assign mem_wdata = {pair_r, pair_g, pair_b};

  bgr2yuv_ram #(
    .WIDTH  (LINE_W),
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // First stage payload.
  always_comb begin
    s1_d.red    = pix_i.red;
    s1_d.green  = pix_i.green;
    s1_d.blue   = pix_i.blue;
    s1_d.sum_r  = pair_r;
    s1_d.sum_g  = pair_g;
    s1_d.sum_b  = pair_b;
    s1_d.chroma = col_q[0] && row_q[0];
    s1_d.fend   = frame_last;
  end

  // Luma from the stage one pixel, block averages from the line-store data.
  assign y_sum = LUMA_R * 16'(s1_q.red) + LUMA_G * 16'(s1_q.green)
               + LUMA_B * 16'(s1_q.blue) + ROUND_U;
  assign y_ofs = 9'(y_sum[15:8]) + LUMA_OFS;
  assign blk_r = 10'(s1_q.sum_r) + 10'(mem_rdata[3*PAIR_W-1:2*PAIR_W]);
  assign blk_g = 10'(s1_q.sum_g) + 10'(mem_rdata[2*PAIR_W-1:PAIR_W]);
  assign blk_b = 10'(s1_q.sum_b) + 10'(mem_rdata[PAIR_W-1:0]);

  always_comb begin
    s2_d.luma   = y_ofs[8] ? 8'd255 : y_ofs[7:0];
    s2_d.avg_r  = blk_r[9:2];
    s2_d.avg_g  = blk_g[9:2];
    s2_d.avg_b  = blk_b[9:2];
    s2_d.chroma = s1_q.chroma;
    s2_d.fend   = s1_q.fend;
  end

  // Chroma products into the output register.
  assign ar_s = $signed({10'd0, s2_q.avg_r});
  assign ag_s = $signed({10'd0, s2_q.avg_g});
  assign ab_s = $signed({10'd0, s2_q.avg_b});
  assign cb_x = CB_R * ar_s + CB_G * ag_s + CB_B * ab_s + ROUND_S;
  assign cr_x = CR_R * ar_s + CR_G * ag_s + CR_B * ab_s + ROUND_S;

  always_comb begin
    s3_d.luma   = s2_q.luma;
    s3_d.chroma = s2_q.chroma;
    s3_d.cb     = s2_q.chroma ? chroma_byte(cb_x) : 8'd0;
    s3_d.cr     = s2_q.chroma ? chroma_byte(cr_x) : 8'd0;
    s3_d.fend   = s2_q.fend;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
      if (en1) begin
        v1_q <= pix_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      s3_q <= s3_d;
    end
  end

  // Result channel.
  assign res_o.valid        = v3_q;
  assign res_o.luma         = s3_q.luma;
  assign res_o.chroma_valid = s3_q.chroma;
  assign res_o.cb           = s3_q.cb;
  assign res_o.cr           = s3_q.cr;
  assign res_o.frame_end    = s3_q.fend;

  // Checks.
  `BGR2YUV_ASSERT_SAME(a_line_one_access, mem_we, !mem_re,
                       "line store written and read in the same cycle")
  `BGR2YUV_ASSERT_NEXT(a_read_marks_chroma, mem_re, v1_q && s1_q.chroma,
                       "line read not followed by a chroma item in stage one")
  `BGR2YUV_ASSERT_SAME(a_chroma_zero, v3_q && !s3_q.chroma, s3_q.cb == 8'd0 && s3_q.cr == 8'd0,
                       "chroma not zero on an item without a complete block")
  `BGR2YUV_ASSERT_NEXT(a_frame_wrap, pix_acc && frame_last, col_q == '0 && row_q == '0,
                       "position not back at the frame start after the last pixel")

endmodule

FILE: dv/yuv420_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV 4:2:0 result checker
// Watches the pixel, result and configuration channels of the converter,
// predicts luma, block chroma and frame end for every accepted pixel, and
// compares each accepted result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module yuv420_result_checker
  import bgr2yuv_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bgr2yuv_pix_if      pix_i,
  bgr2yuv_res_if      res_i,
  bgr2yuv_cfg_if      cfg_i,
  output int unsigned fail_count_o,
  output int unsigned awaiting_o,
  output logic        odd_row_o,
  output int unsigned stored_pairs_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       frame_end;
  } yuv_result_t;

  yuv_result_t       predicted_q[$];
  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;
  logic [11:0]       col_cnt;
  logic [11:0]       row_cnt;
  logic [23:0]       left_rgb;
  logic [LINE_W-1:0] pair_line [MAX_WIDTH/2];
  int unsigned       stored_pairs;
  int unsigned       fail_count;

  // Register value clamped to 2..limit and rounded down to even.
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] value,
                                            input int unsigned limit);
    int unsigned s;
    s = value;
    if (s < 2) s = 2;
    if (s > limit) s = limit;
    return s & 32'hFFFF_FFFE;
  endfunction

  // Floor division by 256, offset to mid-scale and clamped to a byte.
  function automatic logic [7:0] chroma_clamp(input int x);
    int q;
    q = (x >>> 8) + 128;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // Converts one pixel and moves the raster position on by one.
  function automatic yuv_result_t convert_pixel(input logic [7:0] b, input logic [7:0] g,
                                                input logic [7:0] r);
    yuv_result_t       res;
    int unsigned       w;
    int unsigned       h;
    int unsigned       y;
    int unsigned       slot;
    logic [8:0]        sb;
    logic [8:0]        sg;
    logic [8:0]        sr;
    logic [LINE_W-1:0] upper;
    int                ab;
    int                ag;
    int                ar;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    res = '0;
    y = ((66 * r + 129 * g + 25 * b + 128) >> 8) + 16;
    res.luma = (y > 255) ? 8'd255 : y[7:0];
    slot = col_cnt >> 1;

    // Even columns remember the pixel; odd columns form the pair sums.
    if (!col_cnt[0]) begin
      left_rgb = {r, g, b};
    end else begin
      sb = b + left_rgb[7:0];
      sg = g + left_rgb[15:8];
      sr = r + left_rgb[23:16];
      if (!row_cnt[0]) begin
        pair_line[slot] = {sr, sg, sb};
        if (slot + 1 > stored_pairs) stored_pairs = slot + 1;
      end else begin
        upper = pair_line[slot];
        ab = (sb + upper[8:0]) >> 2;
        ag = (sg + upper[17:9]) >> 2;
        ar = (sr + upper[26:18]) >> 2;
        res.cb = chroma_clamp(-38 * ar - 74 * ag + 112 * ab + 128);
        res.cr = chroma_clamp(112 * ar - 94 * ag - 18 * ab + 128);
        res.chroma_valid = 1'b1;
      end
    end

    // A row or frame ends once the counter reaches or passes its last position.
    if (col_cnt + 1 >= w) begin
      col_cnt = '0;
      if (row_cnt + 1 >= h) begin
        res.frame_end = 1'b1;
        row_cnt = '0;
      end else begin
        row_cnt = row_cnt + 1'b1;
      end
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return res;
  endfunction

  // Register writes, pixel predictions and result comparison, all at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    yuv_result_t got;
    yuv_result_t want;
    if (!rst_ni) begin
      predicted_q.delete();
      width_reg    = FRAME_WIDTH_RST;
      height_reg   = FRAME_HEIGHT_RST;
      col_cnt      = '0;
      row_cnt      = '0;
      left_rgb     = '0;
      stored_pairs = 0;
      fail_count   = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_i.data;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_i.data;
          end
          default: begin
          end
        endcase
      end

      if (pix_i.valid && pix_i.ready) begin
        predicted_q.push_back(convert_pixel(pix_i.blue, pix_i.green, pix_i.red));
      end

      if (res_i.valid && res_i.ready) begin
        got = {res_i.luma, res_i.chroma_valid, res_i.cb, res_i.cr, res_i.frame_end};
        if (predicted_q.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $display("%0t: result with no pixel pending: ", $realtime,
                     "luma %0d chroma_valid %0b cb %0d cr %0d frame_end %0b",
                     got.luma, got.chroma_valid, got.cb, got.cr, got.frame_end);
          end
          fail_count++;
        end else begin
          want = predicted_q.pop_front();
          if (got !== want) begin
            if (fail_count < MAX_REPORTS) begin
              $display("%0t: result mismatch: ", $realtime,
                       "expected luma %0d chroma_valid %0b cb %0d cr %0d frame_end %0b, ",
                       want.luma, want.chroma_valid, want.cb, want.cr, want.frame_end,
                       "got luma %0d chroma_valid %0b cb %0d cr %0d frame_end %0b",
                       got.luma, got.chroma_valid, got.cb, got.cr, got.frame_end);
            end
            fail_count++;
          end
        end
      end
    end

    fail_count_o   = fail_count;
    awaiting_o     = predicted_q.size();
    odd_row_o      = row_cnt[0];
    stored_pairs_o = stored_pairs;
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter testbench
// Directed corner pixels and frame-size changes, then random frames under
// random idling on both channels and one long output stall. Results are
// judged by the result checker instantiated beside the converter.
// ----------------------------------------------------------------------------
module testbench;
  import bgr2yuv_pkg::*;

  localparam int unsigned MAX_W         = 4096;
  localparam int unsigned MAX_H         = 4096;
  localparam int unsigned RANDOM_PIXELS = 1850;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 8;

  // Register indexes that the converter does not implement.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Colour corners, packed as blue, green, red, for one 4x2 frame.
  localparam logic [23:0] CORNER_PIXELS [8] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h0000FF,
    24'h00FF00, 24'hFFFFFF, 24'h0000FF, 24'hFF0000
  };

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned awaiting;
  logic        odd_row;
  int unsigned stored_pairs;
  int unsigned pixels_sent;
  bit          gapless;
  bit          hold_done;

  bgr2yuv_pix_if pix_if ();
  bgr2yuv_res_if res_if ();
  bgr2yuv_cfg_if cfg_if ();

  bgra_to_yuv420_converter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  yuv420_result_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (pix_if),
    .res_i         (res_if),
    .cfg_i         (cfg_if),
    .fail_count_o  (fail_count),
    .awaiting_o    (awaiting),
    .odd_row_o     (odd_row),
    .stored_pairs_o(stored_pairs)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Frame size register value: mostly small even sizes, some odd or below
  // the minimum, and a few near or past the top of the range.
  function automatic logic [CFG_W-1:0] random_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return CFG_W'(2 * $urandom_range(1, 8));
    if (pick < 88) return CFG_W'($urandom_range(0, 19));
    if ($urandom_range(0, 1)) return CFG_W'(8191 - $urandom_range(0, 1));
    return CFG_W'(4095 + $urandom_range(0, 3));
  endfunction

  // Offers one pixel item and returns at the edge that accepts it. Valid
  // stays high so that a following item can go out without a gap.
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    int unsigned gap;
    gap = gapless ? 0 : idle_len();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.blue  <= b;
    pix_if.green <= g;
    pix_if.red   <= r;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
  endtask

  // Stops offering pixels and waits until every predicted result has come.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  // One register write; valid drops only after the last of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value,
                           input bit last);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (last) cfg_if.valid <= 1'b0;
  endtask

  // Result receiver: random stalls, runs of steady readiness, and one long
  // hold-off while pixels keep coming so that the pipeline fills up.
  initial begin
    int unsigned gap;
    res_if.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && pixels_sent >= HOLD_AFTER && pix_if.valid) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          res_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned          count;
    int unsigned          target;
    int unsigned          pair_cap;
    logic [CFG_IDX_W-1:0] reg_idx[$];
    logic [CFG_W-1:0]     reg_val[$];
    rst_ni       = 1'b0;
    pixels_sent  = 0;
    gapless      = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.blue  = '0;
    pix_if.green = '0;
    pix_if.red   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FRAME_WIDTH;
    cfg_if.data  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // A 4x2 frame of colour corners: blocks, pair sums and frame end.
    write_reg(REG_FRAME_WIDTH, 13'd4, 1'b0);
    write_reg(REG_FRAME_HEIGHT, 13'd2, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_pixel(CORNER_PIXELS[i][23:16], CORNER_PIXELS[i][15:8], CORNER_PIXELS[i][7:0]);
    end
    wait_drained();

    // Width below the minimum, height past the maximum, writes to spare indexes.
    write_reg(REG_FRAME_WIDTH, 13'd0, 1'b0);
    write_reg(REG_FRAME_HEIGHT, 13'd8191, 1'b0);
    write_reg(REG_SPARE_A, 13'h1FFF, 1'b0);
    write_reg(REG_SPARE_B, 13'h0000, 1'b1);
    repeat (5) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();

    // Odd width widened in the middle of an even row.
    write_reg(REG_FRAME_WIDTH, 13'd7, 1'b1);
    repeat (8) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();

    // Width cut below the current column on an odd row: the row ends at once.
    write_reg(REG_FRAME_WIDTH, 13'd2, 1'b1);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();

    // Height cut below the current row: the frame ends with this row.
    write_reg(REG_FRAME_HEIGHT, 13'd1, 1'b1);
    repeat (2) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // Random phases, each with a fresh setting. On an odd row a new width
    // stays within the pair sums already stored.
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      wait_drained();
      reg_idx.delete();
      reg_val.delete();
      if ($urandom_range(0, 2) != 0) begin
        reg_idx.push_back(REG_FRAME_WIDTH);
        if (odd_row) begin
          pair_cap = (stored_pairs < 8) ? stored_pairs : 8;
          reg_val.push_back(CFG_W'(2 * $urandom_range(1, pair_cap)));
        end else begin
          reg_val.push_back(random_size());
        end
      end
      if ($urandom_range(0, 1) || reg_idx.size() == 0) begin
        reg_idx.push_back(REG_FRAME_HEIGHT);
        reg_val.push_back(random_size());
      end
      if ($urandom_range(0, 7) == 0) begin
        reg_idx.push_back($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B);
        reg_val.push_back(CFG_W'($urandom));
      end
      for (int i = 0; i < reg_idx.size(); i++) begin
        write_reg(reg_idx[i], reg_val[i], i == reg_idx.size() - 1);
      end
      gapless = ($urandom_range(0, 3) == 0);
      count = $urandom_range(1, 160);
      repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && awaiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
